/* rtl/core/ailp_pkg.sv */
`default_nettype none
// ============================================================================
// ailp_pkg
// Shared types, character codes and limits for the ASCII integer literal
// parser.
// ============================================================================
package ailp_pkg;

   // Defaults for the top-level parameters.
   localparam int VALUE_BITS_DEFAULT = 32;
   localparam int MID_DEPTH_DEFAULT  = 4;
   localparam int OUT_DEPTH_DEFAULT  = 4;

   // Character counter saturation point.
   localparam int COUNT_BITS = 7;
   localparam int COUNT_MAX  = 127;

   // Control and status registers.
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_LOW  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_HIGH = 1'b1;
   localparam logic [CSR_DATA_BITS-1:0]  RANGE_LOW_RESET  = 5'd0;
   localparam logic [CSR_DATA_BITS-1:0]  RANGE_HIGH_RESET = 5'd31;

   // Characters of interest.
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UC_A  = 8'h41;
   localparam logic [7:0] CHAR_UC_F  = 8'h46;
   localparam logic [7:0] CHAR_LC_B  = 8'h62;
   localparam logic [7:0] CHAR_LC_X  = 8'h78;

   // Literal formats, as reported on the result channel.
   localparam logic [1:0] FMT_UNS = 2'd0;
   localparam logic [1:0] FMT_SGN = 2'd1;
   localparam logic [1:0] FMT_BIN = 2'd2;
   localparam logic [1:0] FMT_HEX = 2'd3;

   // Error codes.
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_BAD_CHAR  = 2'd1;
   localparam logic [1:0] ERR_TOO_BIG   = 2'd2;
   localparam logic [1:0] ERR_BAD_RANGE = 2'd3;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_item_type;

   typedef struct packed {
      logic [31:0] value;
      logic [1:0]  format;
      logic [1:0]  error;
   } rsp_item_type;

   // What the back end is to do with one character.
   typedef enum logic [1:0] {
      OP_SIGN  = 2'd0,
      OP_CLEAR = 2'd1,
      OP_DIGIT = 2'd2,
      OP_BAD   = 2'd3
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [3:0]  digit;
      logic        over;
      logic [1:0]  fmt;
      logic        last;
   } op_type;

   // Number of decimal digits of 2^vb - 1; evaluated at elaboration only.
   function automatic int dec_digit_limit(input int vb);
      logic [64:0] v;
      int          n;
      v = (65'd1 << vb) - 65'd1;
      n = 0;
      while (v != 65'd0) begin
         v = v / 65'd10;
         n = n + 1;
      end
      return n;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/ailp_fifo.sv */
`default_nettype none
// ============================================================================
// ailp_fifo
// Small register-based first-in first-out queue with a registered fill count.
// ============================================================================
module ailp_fifo #(
   parameter int DEPTH = 4,
   parameter int WIDTH = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   output logic [WIDTH-1:0]           rd_data,
   output logic                       fifo_full,
   output logic                       fifo_empty,
   output logic [$clog2(DEPTH+1)-1:0] fill_count
);
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH+1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data    = mem_ff[rd_ptr_ff];
   assign fifo_full  = (count_ff == CNT_BITS'(DEPTH));
   assign fifo_empty = (count_ff == '0);
   assign fill_count = count_ff;

   // Writers must respect full, readers must respect empty.
   assert property (@(posedge clock) disable iff (reset) wr_en |-> !fifo_full)
      else $error("ailp_fifo: write while full");
   assert property (@(posedge clock) disable iff (reset) rd_en |-> !fifo_empty)
      else $error("ailp_fifo: read while empty");
   // The count tracks the pointers: equal pointers mean empty or full.
   assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff == rd_ptr_ff) |-> (fifo_empty || fifo_full))
      else $error("ailp_fifo: pointers and count disagree");

endmodule
`default_nettype wire

/* rtl/core/ailp_front.sv */
`default_nettype none
// ============================================================================
// ailp_front
// Classifies each incoming character against the literal seen so far and
// turns it into an operation for the accumulating back end.
// ============================================================================
module ailp_front #(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  ailp_pkg::req_item_type req_item,
   output ailp_pkg::op_type       op
);
   import ailp_pkg::*;

   localparam int MAX_BIN = VALUE_BITS;
   localparam int MAX_HEX = (VALUE_BITS + 3) / 4;
   localparam int MAX_DEC = dec_digit_limit(VALUE_BITS);

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [7:0]            first_ff, first_in;
   logic [1:0]            fmt_ff, fmt_in;
   logic [1:0]            fmt_new;
   logic [7:0]            ch;
   logic [7:0]            digits;
   logic [7:0]            max_digits;
   logic [1:0]            prefix_len;
   logic                  legal;
   logic [3:0]            dval;
   op_kind_type           kind;

   always_comb begin
      ch      = req_item.ch;
      fmt_new = fmt_ff;
      kind    = OP_DIGIT;

      unique case (fmt_ff)
         FMT_UNS: prefix_len = 2'd0;
         FMT_SGN: prefix_len = 2'd1;
         default: prefix_len = 2'd2;
      endcase
      digits = {1'b0, count_ff} + 8'd1 - {6'd0, prefix_len};

      if (count_ff == '0) begin
         if (ch == CHAR_MINUS) begin
            fmt_new = FMT_SGN;
            kind    = OP_SIGN;
         end
      end else if (count_ff == COUNT_BITS'(1) && first_ff == CHAR_ZERO &&
                   (ch == CHAR_LC_B || ch == CHAR_LC_X)) begin
         fmt_new = (ch == CHAR_LC_B) ? FMT_BIN : FMT_HEX;
         kind    = OP_CLEAR;
      end

      // Digit value in the format that holds before this character.
      legal = 1'b0;
      dval  = 4'd0;
      if (fmt_ff == FMT_BIN) begin
         legal = (ch == CHAR_ZERO) || (ch == CHAR_ONE);
         dval  = 4'(ch - CHAR_ZERO);
      end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         legal = 1'b1;
         dval  = 4'(ch - CHAR_ZERO);
      end else if (fmt_ff == FMT_HEX && ch >= CHAR_UC_A && ch <= CHAR_UC_F) begin
         legal = 1'b1;
         dval  = 4'(ch - (CHAR_UC_A - 8'd10));
      end

      if (kind == OP_DIGIT && !legal) begin
         kind = OP_BAD;
      end

      unique case (fmt_ff)
         FMT_BIN: max_digits = 8'(MAX_BIN);
         FMT_HEX: max_digits = 8'(MAX_HEX);
         default: max_digits = 8'(MAX_DEC);
      endcase

      op.kind  = kind;
      op.digit = dval;
      op.over  = (digits > max_digits);
      op.fmt   = fmt_new;
      op.last  = req_item.last;

      count_in = (count_ff == COUNT_BITS'(COUNT_MAX)) ? count_ff : count_ff + 1'b1;
      first_in = (count_ff == '0) ? ch : first_ff;
      fmt_in   = fmt_new;
      if (req_item.last) begin
         count_in = '0;
         first_in = '0;
         fmt_in   = FMT_UNS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         first_ff <= '0;
         fmt_ff   <= FMT_UNS;
      end else if (accept) begin
         count_ff <= count_in;
         first_ff <= first_in;
         fmt_ff   <= fmt_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/ailp_back.sv */
`default_nettype none
// ============================================================================
// ailp_back
// Accumulates digits with saturation and overflow detection, then formats
// the finished literal: sign, bit range extraction and error code.
// ============================================================================
module ailp_back #(
   parameter int VALUE_BITS = 32,
   parameter int OUT_DEPTH  = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ailp_pkg::op_type                   op,
   input  logic                               op_valid,
   output logic                               op_take,
   input  logic [$clog2(OUT_DEPTH+1)-1:0]     out_count,
   output logic                               out_wr,
   output ailp_pkg::rsp_item_type             out_item,
   input  logic [ailp_pkg::CSR_DATA_BITS-1:0] range_low,
   input  logic [ailp_pkg::CSR_DATA_BITS-1:0] range_high
);
   import ailp_pkg::*;

   localparam int VB       = VALUE_BITS;
   localparam int SUM_BITS = VB + 5;
   localparam int CNT_BITS = $clog2(OUT_DEPTH+1);

   typedef struct packed {
      logic [VB-1:0] acc;
      logic [1:0]    fmt;
      logic          bad;
      logic          too_big;
   } finish_type;

   logic [VB-1:0]       acc_ff, acc_in;
   logic                bad_ff, bad_in;
   logic                too_big_ff, too_big_in;
   logic                fin_valid_ff, fin_valid_in;
   finish_type          fin_ff, fin_in;

   logic [SUM_BITS-1:0] acc_ext;
   logic [SUM_BITS-1:0] scaled;
   logic [SUM_BITS-1:0] sum;
   logic [SUM_BITS-1:0] limit;
   logic                room;

   // Room in the result queue, counting the slot held for the finish stage.
   assign room    = ({1'b0, out_count} + (CNT_BITS+1)'(fin_valid_ff))
                    < (CNT_BITS+1)'(OUT_DEPTH);
   assign op_take = op_valid && (!op.last || room);

   always_comb begin
      acc_ext = SUM_BITS'(acc_ff);
      unique case (op.fmt)
         FMT_BIN: scaled = acc_ext << 1;
         FMT_HEX: scaled = acc_ext << 4;
         default: scaled = (acc_ext << 3) + (acc_ext << 1);
      endcase
      sum = scaled + SUM_BITS'(op.digit);
      if (op.fmt == FMT_SGN) begin
         limit = SUM_BITS'(1) << (VB - 1);
      end else begin
         limit = (SUM_BITS'(1) << VB) - SUM_BITS'(1);
      end

      acc_in     = acc_ff;
      bad_in     = bad_ff;
      too_big_in = too_big_ff;
      if (op_take) begin
         unique case (op.kind)
            OP_SIGN: begin
            end
            OP_CLEAR: begin
               acc_in     = '0;
               too_big_in = 1'b0;
            end
            OP_BAD: begin
               bad_in = 1'b1;
            end
            OP_DIGIT: begin
               if (op.over || too_big_ff) begin
                  too_big_in = 1'b1;
               end else if (sum > limit) begin
                  too_big_in = 1'b1;
                  acc_in     = limit[VB-1:0];
               end else begin
                  acc_in = sum[VB-1:0];
               end
            end
            default: begin
            end
         endcase
      end

      fin_in.acc     = acc_in;
      fin_in.fmt     = op.fmt;
      fin_in.bad     = bad_in;
      fin_in.too_big = too_big_in;
      fin_valid_in   = op_take && op.last;

      if (op_take && op.last) begin
         acc_in     = '0;
         bad_in     = 1'b0;
         too_big_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         bad_ff       <= 1'b0;
         too_big_ff   <= 1'b0;
         fin_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         bad_ff       <= bad_in;
         too_big_ff   <= too_big_in;
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_valid_in) begin
         fin_ff <= fin_in;
      end
   end

   // Finish stage: sign, range extraction and error priority.
   logic [VB-1:0]    signed_val;
   logic [VB+31:0]   shifted;
   logic [5:0]       range_len;
   logic [31:0]      range_mask;
   logic             range_bad;

   always_comb begin
      signed_val = (fin_ff.fmt == FMT_SGN) ? (VB'(0) - fin_ff.acc) : fin_ff.acc;
      shifted    = (VB+32)'(signed_val) >> range_low;
      range_len  = {1'b0, range_high} - {1'b0, range_low} + 6'd1;
      range_mask = ~(32'hFFFF_FFFF << range_len);
      range_bad  = (range_low > range_high) || (32'(range_high) >= VB);

      out_item.format = fin_ff.fmt;
      out_item.value  = '0;
      priority if (fin_ff.bad) begin
         out_item.error = ERR_BAD_CHAR;
      end else if (fin_ff.too_big) begin
         out_item.error = ERR_TOO_BIG;
      end else if (range_bad) begin
         out_item.error = ERR_BAD_RANGE;
      end else begin
         out_item.error = ERR_NONE;
         out_item.value = shifted[31:0] & range_mask;
      end
   end

   assign out_wr = fin_valid_ff;

endmodule
`default_nettype wire

/* rtl/core/ascii_integer_literal_parser_core.sv */
`default_nettype none
// ============================================================================
// ascii_integer_literal_parser_core
// Parses binary, hex and signed or unsigned decimal ASCII literals, one
// character per transaction, into a range-extracted value with codes.
// ============================================================================
//
//  Channel   Handshake           Moves                     Width
//  -------   -----------------   -----------------------   -----------------
//  request   push / full         one character, last flag  req_item_type
//  response  pop / empty         value, format, error      rsp_item_type
//  csr       valid / ready       register index and data   csr_index/wdata
//
// One character is accepted every cycle while full is low; the front end
// classifies it in the accept cycle and the back end accumulates it as it
// leaves the request queue.
// A result passes from the request queue through the accumulate step and
// the registered finish stage into the response queue, and can be popped
// from there once it has been written.
// Reset clears the literal state, both queues and loads the range registers
// with 0 and 31; it needs no clearing pass.
// A stalled response side fills the response queue, then the request queue,
// and only then raises full; the csr channel is always ready.
//
module ascii_integer_literal_parser_core #(
   parameter int VALUE_BITS = ailp_pkg::VALUE_BITS_DEFAULT,
   parameter int MID_DEPTH  = ailp_pkg::MID_DEPTH_DEFAULT,
   parameter int OUT_DEPTH  = ailp_pkg::OUT_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                push,
   output logic                                full,
   input  ailp_pkg::req_item_type              req_item,
   // Response channel.
   output logic                                empty,
   input  logic                                pop,
   output ailp_pkg::rsp_item_type              rsp_item,
   // Register write channel.
   input  logic                                valid,
   output logic                                ready,
   input  logic [ailp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ailp_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import ailp_pkg::*;

   localparam int OP_BITS  = $bits(op_type);
   localparam int RSP_BITS = $bits(rsp_item_type);
   localparam int OUT_CNT  = $clog2(OUT_DEPTH+1);
   localparam int MID_CNT  = $clog2(MID_DEPTH+1);

   logic [CSR_DATA_BITS-1:0] range_low_ff, range_low_in;
   logic [CSR_DATA_BITS-1:0] range_high_ff, range_high_in;

   logic                in_accept;
   op_type              front_op;
   op_type              mid_op;
   logic                mid_full;
   logic                mid_empty;
   logic [MID_CNT-1:0]  mid_count;
   logic                op_take;
   logic                out_wr;
   rsp_item_type        out_item;
   logic                out_full;
   logic [OUT_CNT-1:0]  out_count;
   logic                out_pop;
   logic [RSP_BITS-1:0] out_data;
   logic [OP_BITS-1:0]  mid_data;

   // The register channel never stalls; writes are registered into the range registers.
   assign ready = 1'b1;

   always_comb begin
      range_low_in  = range_low_ff;
      range_high_in = range_high_ff;
      if (valid) begin
         unique case (csr_index)
            CSR_RANGE_LOW:  range_low_in  = csr_wdata;
            CSR_RANGE_HIGH: range_high_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff  <= RANGE_LOW_RESET;
         range_high_ff <= RANGE_HIGH_RESET;
      end else begin
         range_low_ff  <= range_low_in;
         range_high_ff <= range_high_in;
      end
   end

   // A character is taken whenever the request queue has a free slot.
   assign in_accept = push && !mid_full;
   assign full      = mid_full;

   ailp_front #(
      .VALUE_BITS(VALUE_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (in_accept),
      .req_item (req_item),
      .op       (front_op)
   );

   // Decouples classification from accumulation so either side may stall.
   ailp_fifo #(
      .DEPTH(MID_DEPTH),
      .WIDTH(OP_BITS)
   ) u_mid_fifo (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (in_accept),
      .wr_data    (front_op),
      .rd_en      (op_take),
      .rd_data    (mid_data),
      .fifo_full  (mid_full),
      .fifo_empty (mid_empty),
      .fill_count (mid_count)
   );

   assign mid_op = op_type'(mid_data);

   ailp_back #(
      .VALUE_BITS(VALUE_BITS),
      .OUT_DEPTH (OUT_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .op         (mid_op),
      .op_valid   (!mid_empty),
      .op_take    (op_take),
      .out_count  (out_count),
      .out_wr     (out_wr),
      .out_item   (out_item),
      .range_low  (range_low_ff),
      .range_high (range_high_ff)
   );

   // Results wait here until the consumer pops them.
   assign out_pop = pop && !empty;

   ailp_fifo #(
      .DEPTH(OUT_DEPTH),
      .WIDTH(RSP_BITS)
   ) u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (out_wr),
      .wr_data    (out_item),
      .rd_en      (out_pop),
      .rd_data    (out_data),
      .fifo_full  (out_full),
      .fifo_empty (empty),
      .fill_count (out_count)
   );

   assign rsp_item = rsp_item_type'(out_data);

   // The back end only moves an operation out of a non-empty request queue.
   assert property (@(posedge clock) disable iff (reset) op_take |-> !mid_empty)
      else $error("core: operation taken from empty request queue");
   // The finish stage always has a reserved slot in the response queue.
   assert property (@(posedge clock) disable iff (reset) out_wr |-> !out_full)
      else $error("core: result written into full response queue");
   // The request queue never reports more entries than it holds.
   assert property (@(posedge clock) disable iff (reset)
      mid_count <= MID_CNT'(MID_DEPTH))
      else $error("core: request queue count out of range");

endmodule
`default_nettype wire
